// ===== rtl/square_noise_sound_generator_unit_macros.svh =====
// Assertion macros used by the sound generator checker
`ifndef SQUARE_NOISE_SOUND_GENERATOR_UNIT_MACROS_SVH
`define SQUARE_NOISE_SOUND_GENERATOR_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset
`define SNG_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sound generator check failed");

// Next-cycle implication, sampled on clk, off during reset
`define SNG_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sound generator check failed");

`endif

// ===== rtl/snd_pkg.sv =====
// Types, constants and helper functions of the sound generator
package snd_pkg;

  localparam int StepW  = 20;
  localparam int PerW   = 10;
  localparam int FracW  = 10;
  localparam int DivW   = 11;
  localparam int AmpW   = 13;
  localparam int MixW   = 16;
  localparam int OutW   = 17;
  localparam int LfsrW  = 16;
  localparam int NoiseSteps = 8;
  localparam int QDepth = 2;

  localparam logic [2:0] SEL_NOISE_MODE = 3'd6;
  localparam logic [2:0] SEL_NOISE_ATT  = 3'd7;
  localparam logic [2:0] SEL_TONE0_PER  = 3'd0;
  localparam logic [2:0] SEL_TONE1_PER  = 3'd2;
  localparam logic [2:0] SEL_TONE2_PER  = 3'd4;
  localparam logic [1:0] NOISE_CH       = 2'd3;
  localparam logic [1:0] NOISE_TONE_SRC = 2'd3;
  localparam logic [LfsrW-1:0] LFSR_SEED = 16'h8000;
  localparam logic [3:0] ATT_SILENT     = 4'hF;
  localparam logic [DivW-1:0] FULL_PERIOD = 11'd1024;
  localparam logic [DivW-1:0] NOISE_BASE  = 11'd16;

  typedef enum logic [1:0] {
    K_LATCH,
    K_DATA,
    K_SAMPLE
  } kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_DIV,
    S_NOISE,
    S_NAMP,
    S_DONE
  } state_t;

  typedef struct packed {
    logic                   opcode;
    logic [7:0]             data_byte;
    logic signed [MixW-1:0] mix_in;
    logic                   block_end;
  } in_word_t;

  typedef struct packed {
    logic signed [OutW-1:0] mix_out;
    logic                   block_end_out;
  } out_word_t;

  typedef struct packed {
    kind_t                  kind;
    logic [7:0]             data_byte;
    logic signed [MixW-1:0] mix_in;
    logic                   block_end;
  } cmd_t;

  // head of the command queue as seen by the engine
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } head_t;

  // 2 dB step amplitude table, last entry silent
  function automatic logic [AmpW-2:0] amp_rom(input logic [3:0] att);
    logic [AmpW-2:0] a;
    unique case (att)
      4'd0:  a = 12'd4000;
      4'd1:  a = 12'd3177;
      4'd2:  a = 12'd2524;
      4'd3:  a = 12'd2005;
      4'd4:  a = 12'd1592;
      4'd5:  a = 12'd1265;
      4'd6:  a = 12'd1005;
      4'd7:  a = 12'd798;
      4'd8:  a = 12'd634;
      4'd9:  a = 12'd504;
      4'd10: a = 12'd400;
      4'd11: a = 12'd318;
      4'd12: a = 12'd252;
      4'd13: a = 12'd200;
      4'd14: a = 12'd159;
      default: a = 12'd0;
    endcase
    return a;
  endfunction

  function automatic logic signed [AmpW-1:0] signed_amp(input logic neg,
                                                         input logic [3:0] att);
    logic signed [AmpW-1:0] a;
    a = signed'({1'b0, amp_rom(att)});
    return neg ? -a : a;
  endfunction

  // period of zero means the full 1024
  function automatic logic [DivW-1:0] whole_period(input logic [PerW-1:0] p);
    return (p == '0) ? FULL_PERIOD : {1'b0, p};
  endfunction

  // one shift of the noise register, tap selects the white-noise feedback
  function automatic logic [LfsrW-1:0] lfsr_step(input logic [LfsrW-1:0] s,
                                                 input logic tap);
    logic fb;
    fb = tap ? (s[0] ^ s[3]) : s[0];
    return {fb, s[LfsrW-1:1]};
  endfunction

endpackage

// ===== rtl/snd_front.sv =====
// Front end: classifies incoming words and queues them for the engine
module snd_front
  import snd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  in_word_t in_word,
  output logic     full,
  input  logic     pop_head,
  output head_t    head
);

  localparam int PtrW = $clog2(QDepth);
  localparam int CntW = $clog2(QDepth + 1);

  cmd_t            q_r [QDepth];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            do_push, do_pop;
  cmd_t            cmd;

  // classify the word
  always_comb begin
    cmd.data_byte = in_word.data_byte;
    cmd.mix_in    = in_word.mix_in;
    cmd.block_end = in_word.block_end;
    if (in_word.opcode) begin
      cmd.kind = K_SAMPLE;
    end else if (in_word.data_byte[7]) begin
      cmd.kind = K_LATCH;
    end else begin
      cmd.kind = K_DATA;
    end
  end

  assign full    = (cnt_r == CntW'(QDepth));
  assign do_push = push && !full;
  assign do_pop  = pop_head && (cnt_r != '0);

  assign head.valid = (cnt_r != '0);
  assign head.cmd   = q_r[rd_ptr_r];

  // pointer and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(QDepth - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(QDepth - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= cmd;
    end
  end

endmodule

// ===== rtl/snd_back.sv =====
// Engine: register writes, channel counters via a shared divider, noise, mix
module snd_back
  import snd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  head_t             head,
  output logic              pop_head,
  input  logic              cfg_valid,
  input  logic [StepW-1:0]  cfg_data,
  output logic              empty,
  input  logic              pop,
  output out_word_t         out_word
);

  localparam int CntW = PerW + FracW;

  state_t                 state_r, state_nxt;
  logic [StepW-1:0]       step_r, step_nxt;
  logic [PerW-1:0]        tp_r [3];
  logic [PerW-1:0]        tp_nxt [3];
  logic [CntW-1:0]        tc_r [3];
  logic [CntW-1:0]        tc_nxt [3];
  logic [2:0]             ts_r, ts_nxt;
  logic [3:0]             att_r [4];
  logic [3:0]             att_nxt [4];
  logic [2:0]             nmode_r, nmode_nxt;
  logic [2:0]             lsel_r, lsel_nxt;
  logic [CntW-1:0]        ncnt_r, ncnt_nxt;
  logic [LfsrW-1:0]       lfsr_r, lfsr_nxt;
  logic                   nsign_r, nsign_nxt;
  logic [1:0]             ch_r, ch_nxt;
  logic [DivW-1:0]        dvd_r, dvd_nxt;
  logic [PerW-1:0]        rem_r, rem_nxt;
  logic [DivW-1:0]        quo_r, quo_nxt;
  logic [FracW-1:0]       frac_r, frac_nxt;
  logic [3:0]             bit_r, bit_nxt;
  logic [DivW-1:0]        per_r, per_nxt;
  logic signed [OutW-1:0] acc_r, acc_nxt;
  logic                   be_r, be_nxt;
  logic [DivW-1:0]        nleft_r, nleft_nxt;
  logic                   outv_r, outv_nxt;
  out_word_t              outw_r, outw_nxt;

  logic [1:0]             tidx;
  logic [CntW:0]          csum;
  logic [DivW-1:0]        trial;
  logic                   ge;
  logic                   sgn;
  logic [3:0]             nstep;
  logic [LfsrW-1:0]       chain [NoiseSteps+1];
  logic [2:0]             sel;

  assign empty    = !outv_r;
  assign out_word = outw_r;
  assign tidx     = (ch_r == NOISE_CH) ? 2'd0 : ch_r;
  assign sel      = head.cmd.data_byte[6:4];

  // noise register steps for this cycle
  always_comb begin
    nstep = (nleft_r >= DivW'(NoiseSteps)) ? 4'(NoiseSteps) : nleft_r[3:0];
    chain[0] = lfsr_r;
    for (int i = 0; i < NoiseSteps; i++) begin
      chain[i+1] = lfsr_step(chain[i], nmode_r[2]);
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (head.valid && head.cmd.kind == K_SAMPLE && step_r != '0) begin
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: state_nxt = S_DIV;
      S_DIV: begin
        if (bit_r == '0) begin
          state_nxt = (ch_r == NOISE_CH) ? S_NOISE : S_LOAD;
        end
      end
      S_NOISE: begin
        if (nleft_r == '0) begin
          state_nxt = S_NAMP;
        end
      end
      S_NAMP: state_nxt = S_DONE;
      S_DONE: begin
        if (!outv_r) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // queue pop
  always_comb begin
    pop_head = 1'b0;
    if (state_r == S_IDLE && head.valid) begin
      if (head.cmd.kind == K_SAMPLE && step_r == '0) begin
        pop_head = !outv_r;
      end else begin
        pop_head = 1'b1;
      end
    end
  end

  // datapath
  always_comb begin
    step_nxt  = step_r;
    tp_nxt    = tp_r;
    tc_nxt    = tc_r;
    ts_nxt    = ts_r;
    att_nxt   = att_r;
    nmode_nxt = nmode_r;
    lsel_nxt  = lsel_r;
    ncnt_nxt  = ncnt_r;
    lfsr_nxt  = lfsr_r;
    nsign_nxt = nsign_r;
    ch_nxt    = ch_r;
    dvd_nxt   = dvd_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    frac_nxt  = frac_r;
    bit_nxt   = bit_r;
    per_nxt   = per_r;
    acc_nxt   = acc_r;
    be_nxt    = be_r;
    nleft_nxt = nleft_r;
    outv_nxt  = outv_r;
    outw_nxt  = outw_r;
    csum      = '0;
    trial     = {rem_r, dvd_r[DivW-1]};
    ge        = (trial >= per_r);
    sgn       = 1'b0;

    if (cfg_valid) begin
      step_nxt = cfg_data;
    end
    if (pop && outv_r) begin
      outv_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (head.valid) begin
          unique case (head.cmd.kind)
            K_LATCH: begin
              lsel_nxt = sel;
              if (sel == SEL_NOISE_MODE) begin
                nmode_nxt = head.cmd.data_byte[2:0];
                lfsr_nxt  = LFSR_SEED;
              end else if (sel == SEL_NOISE_ATT) begin
                att_nxt[3] = head.cmd.data_byte[3:0];
              end else if (sel[0]) begin
                att_nxt[sel[2:1]] = head.cmd.data_byte[3:0];
              end else begin
                tp_nxt[sel[2:1]] = {tp_r[sel[2:1]][PerW-1:4], head.cmd.data_byte[3:0]};
              end
            end
            K_DATA: begin
              if (lsel_r == SEL_TONE0_PER || lsel_r == SEL_TONE1_PER ||
                  lsel_r == SEL_TONE2_PER) begin
                tp_nxt[lsel_r[2:1]] = {head.cmd.data_byte[5:0], tp_r[lsel_r[2:1]][3:0]};
              end
            end
            K_SAMPLE: begin
              if (step_r == '0) begin
                if (!outv_r) begin
                  outw_nxt.mix_out       = OutW'(head.cmd.mix_in);
                  outw_nxt.block_end_out = head.cmd.block_end;
                  outv_nxt               = 1'b1;
                end
              end else begin
                acc_nxt = OutW'(head.cmd.mix_in);
                be_nxt  = head.cmd.block_end;
                ch_nxt  = '0;
              end
            end
            default: ;
          endcase
        end
      end

      // counter plus step, set up the divider
      S_LOAD: begin
        if (ch_r == NOISE_CH) begin
          csum = {1'b0, ncnt_r} + {1'b0, step_r};
          per_nxt = (nmode_r[1:0] == NOISE_TONE_SRC) ? whole_period(tp_r[2])
                                                     : (NOISE_BASE << nmode_r[1:0]);
        end else begin
          csum = {1'b0, tc_r[tidx]} + {1'b0, step_r};
          per_nxt = whole_period(tp_r[tidx]);
        end
        dvd_nxt  = csum[CntW:FracW];
        frac_nxt = csum[FracW-1:0];
        rem_nxt  = '0;
        quo_nxt  = '0;
        bit_nxt  = 4'(DivW - 1);
      end

      // one restoring divide step per cycle: wraps and new counter
      S_DIV: begin
        rem_nxt = ge ? PerW'(trial - per_r) : trial[PerW-1:0];
        quo_nxt = {quo_r[DivW-2:0], ge};
        dvd_nxt = {dvd_r[DivW-2:0], 1'b0};
        bit_nxt = bit_r - 1'b1;
        if (bit_r == '0) begin
          if (ch_r == NOISE_CH) begin
            ncnt_nxt  = {rem_nxt, frac_r};
            nleft_nxt = quo_nxt;
          end else begin
            tc_nxt[tidx] = {rem_nxt, frac_r};
            sgn          = ts_r[tidx] ^ quo_nxt[0];
            ts_nxt[tidx] = sgn;
            acc_nxt      = acc_r + OutW'(signed_amp(sgn, att_r[tidx]));
            ch_nxt       = ch_r + 1'b1;
          end
        end
      end

      // up to eight noise shifts per cycle
      S_NOISE: begin
        if (nleft_r != '0) begin
          lfsr_nxt  = chain[nstep];
          nsign_nxt = !chain[nstep][0];
          nleft_nxt = nleft_r - DivW'(nstep);
        end
      end

      S_NAMP: begin
        acc_nxt = acc_r + OutW'(signed_amp(nsign_r, att_r[3]));
      end

      S_DONE: begin
        if (!outv_r) begin
          outw_nxt.mix_out       = acc_r;
          outw_nxt.block_end_out = be_r;
          outv_nxt               = 1'b1;
        end
      end

      default: ;
    endcase
  end

  // control and channel state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
      for (int i = 0; i < 3; i++) begin
        tp_r[i] <= '0;
        tc_r[i] <= '0;
      end
      ts_r <= '0;
      for (int i = 0; i < 4; i++) begin
        att_r[i] <= ATT_SILENT;
      end
      nmode_r <= '0;
      lsel_r  <= '0;
      ncnt_r  <= '0;
      lfsr_r  <= LFSR_SEED;
      nsign_r <= 1'b0;
      ch_r    <= '0;
      bit_r   <= '0;
      nleft_r <= '0;
      outv_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      tp_r    <= tp_nxt;
      tc_r    <= tc_nxt;
      ts_r    <= ts_nxt;
      att_r   <= att_nxt;
      nmode_r <= nmode_nxt;
      lsel_r  <= lsel_nxt;
      ncnt_r  <= ncnt_nxt;
      lfsr_r  <= lfsr_nxt;
      nsign_r <= nsign_nxt;
      ch_r    <= ch_nxt;
      bit_r   <= bit_nxt;
      nleft_r <= nleft_nxt;
      outv_r  <= outv_nxt;
    end
  end

  // working payload
  always_ff @(posedge clk) begin
    dvd_r  <= dvd_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    frac_r <= frac_nxt;
    per_r  <= per_nxt;
    acc_r  <= acc_nxt;
    be_r   <= be_nxt;
    outw_r <= outw_nxt;
  end

endmodule

// ===== rtl/square_noise_sound_generator_unit.sv =====
// Top level of the three-tone, one-noise sound generator
//
// Input side is a queue: a word is taken when push is high and full is low.
// opcode 0 words carry a control byte (latch/data writes), opcode 1 words
// ask for one sample: mix_in plus the four channel amplitudes.
// Result side is a queue too: while empty is low the oldest sample sits on
// out_word and leaves when pop is high. Control writes give no result.
// cfg_data (resample step, 10 fraction bits) is written on cfg_valid and the
// port is always ready; the user writes it only while the block is idle, the
// block itself does not enforce this. A two-word command queue sits before
// the engine, so words keep coming while a result waits.
// A sample runs the shared 11-step divider once per channel, then the
// 8-shifts-per-cycle noise unit for the noise shifts due, then adds the
// noise amplitude. A zero step returns mix_in unchanged, registered,
// once the result side is free.
// Reset clears all channels: silent, periods zero, noise seed 0x8000.
// If pop stays low the result holds and the engine waits once it has the
// next sample ready; the queue then fills and full goes high.
module square_noise_sound_generator_unit
  import snd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  output logic             full,
  input  in_word_t         in_word,
  output logic             empty,
  input  logic             pop,
  output out_word_t        out_word,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [StepW-1:0] cfg_data
);

  head_t head;
  logic  pop_head;

  assign cfg_ready = 1'b1;

  snd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .in_word  (in_word),
    .full     (full),
    .pop_head (pop_head),
    .head     (head)
  );

  snd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .pop_head  (pop_head),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .empty     (empty),
    .pop       (pop),
    .out_word  (out_word)
  );

endmodule

// ===== rtl/snd_checker.sv =====
// Port-level checks of the sound generator, bound to the top level
`include "square_noise_sound_generator_unit_macros.svh"

module snd_checker
  import snd_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             push,
  input logic             full,
  input in_word_t         in_word,
  input logic             empty,
  input logic             pop,
  input out_word_t        out_word,
  input logic             cfg_valid,
  input logic             cfg_ready,
  input logic [StepW-1:0] cfg_data
);

  // samples taken but not yet handed out
  logic [2:0] pend_r, pend_nxt;
  logic       smp_in, res_out;

  assign smp_in  = push && !full && in_word.opcode;
  assign res_out = pop && !empty;

  always_comb begin
    pend_nxt = pend_r;
    if (smp_in && !res_out) begin
      pend_nxt = pend_r + 1'b1;
    end else if (!smp_in && res_out) begin
      pend_nxt = pend_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  `SNG_ASSERT_NOW(a_empty_after_reset, $past(!rst_n), empty)
  `SNG_ASSERT_NEXT(a_result_holds, !empty && !pop, !empty && $stable(out_word))
  `SNG_ASSERT_NOW(a_result_has_sample, !empty, pend_r != 3'd0)
  `SNG_ASSERT_NOW(a_cfg_write_ok, cfg_valid, cfg_ready || $stable(cfg_data))

endmodule

bind square_noise_sound_generator_unit snd_checker u_snd_checker (.*);
